/* hw/rtl/kdcl_pkg.sv */
`default_nettype none

package kdcl_pkg;

  localparam int unsigned NumKeys     = 13;
  localparam int unsigned KeyIdxW     = $clog2(NumKeys);
  localparam int unsigned DebounceW   = 8;
  localparam int unsigned HoldW       = 16;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned InTdataW    = 16;
  localparam int unsigned OutTdataW   = 24;

  // keys that can produce a click: bits 0-8, 11 and 12
  localparam logic [NumKeys-1:0] ClickMask = NumKeys'(13'h19FF);
  localparam int unsigned        TopKey    = 8;

  localparam logic [DebounceW-1:0] DebounceMax      = '1;
  localparam logic [DebounceW-1:0] DebounceReset    = DebounceW'(2);
  localparam logic [HoldW-1:0]     LongPressReset   = HoldW'(400);

  typedef enum logic [0:0] {
    CfgDebounce  = 1'b0,
    CfgLongPress = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [HoldW-1:0]     long_press_ticks;
  } kdcl_cfg_t;

  typedef struct packed {
    logic                long_press;
    logic [KeyIdxW-1:0]  click_key;
    logic                click_valid;
    logic [NumKeys-1:0]  pressed_keys;
  } kdcl_result_t;

endpackage

`default_nettype wire

/* hw/rtl/kdcl_core.sv */
`default_nettype none

module kdcl_core
  import kdcl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [NumKeys-1:0] sample_i,
  input  wire kdcl_cfg_t          cfg_i,
  output      kdcl_result_t       result_o
);

  logic [NumKeys-1:0]   prev_q, prev_d;
  logic [DebounceW-1:0] cnt_q, cnt_d;
  logic [NumKeys-1:0]   stable_q, stable_d;
  logic [NumKeys-1:0]   press_q, press_d;
  logic [NumKeys-1:0]   release_q, release_d;
  logic [HoldW-1:0]     hold_q, hold_d;

  logic [DebounceW-1:0] cnt_inc;
  logic [NumKeys-1:0]   press_n, release_n, both;
  logic [HoldW-1:0]     hold_inc;
  logic                 pick_hit;
  logic [KeyIdxW-1:0]   pick_idx;

  always_comb begin
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    stable_d  = stable_q;
    press_d   = press_q;
    release_d = release_q;
    hold_d    = hold_q;
    press_n   = press_q;
    release_n = release_q;
    both      = '0;
    pick_hit  = 1'b0;
    pick_idx  = '0;
    cnt_inc   = (cnt_q < DebounceMax) ? cnt_q + DebounceW'(1) : cnt_q;
    hold_inc  = hold_q + HoldW'(1);

    result_o.pressed_keys = stable_q;
    result_o.click_valid  = 1'b0;
    result_o.click_key    = '0;
    result_o.long_press   = 1'b0;

    if (sample_i != prev_q) begin
      prev_d = sample_i;
      cnt_d  = '0;
    end else begin
      cnt_d = cnt_inc;
      if (cnt_inc >= cfg_i.debounce_ticks) begin
        cnt_d     = cfg_i.debounce_ticks;
        press_n   = press_q | (~stable_q & sample_i);
        release_n = release_q | (stable_q & ~sample_i);
        stable_d  = sample_i;
      end

      // lowest clickable key with both edges seen wins
      both = press_n & release_n & ClickMask;
      for (int i = NumKeys - 1; i >= 0; i--) begin
        if (both[i]) begin
          pick_hit = 1'b1;
          pick_idx = KeyIdxW'(i);
        end
      end

      press_d   = press_n;
      release_d = release_n;
      if (pick_hit) begin
        press_d[pick_idx]   = 1'b0;
        release_d[pick_idx] = 1'b0;
      end

      // hold counter runs on the top key, free across releases
      if (!pick_hit && stable_d[TopKey]) begin
        if (hold_inc >= cfg_i.long_press_ticks) begin
          hold_d              = '0;
          result_o.long_press = 1'b1;
        end else begin
          hold_d = hold_inc;
        end
      end

      result_o.pressed_keys = stable_d;
      result_o.click_valid  = pick_hit;
      result_o.click_key    = pick_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      cnt_q     <= '0;
      stable_q  <= '0;
      press_q   <= '0;
      release_q <= '0;
      hold_q    <= '0;
    end else if (step_i) begin
      prev_q    <= prev_d;
      cnt_q     <= cnt_d;
      stable_q  <= stable_d;
      press_q   <= press_d;
      release_q <= release_d;
      hold_q    <= hold_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/key_debounce_click_longpress.sv */
// key debounce with click and long-press detection
//
// input stream: one beat per scan tick, tdata[12:0] holds the raw active-low
// pin levels of 13 keys and limit switches (upper bits ignored)
// output stream: one beat per input beat, in order; tdata carries the
// debounced pressed vector, a click flag with the clicked key index and a
// one-tick long-press pulse for the top key (bit 8)
// config port: cfg_we_i writes register cfg_idx_i (0 = debounce ticks,
// 1 = long-press ticks) from cfg_data_i on the same edge; write only while
// the block is idle
// latency: a result beat is offered the cycle after its input beat is taken
// throughput: one beat per cycle; the debounce state, edge latches and hold
// counter are updated by one pass of logic between the input and the output
// register
// reset: all key state and the output valid flag clear, registers return to
// debounce 2 and long press 400
// stall: the output register holds its beat while m_axis_tready is low;
// s_axis_tready stays high as long as the output beat is taken in the
// same cycle or the output register is empty

`default_nettype none

module key_debounce_click_longpress
  import kdcl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // raw_pins[12:0], zero padding above
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // pressed_keys[12:0], click_valid[13], click_key[17:14], long_press[18], zero pad
  output      logic [OutTdataW-1:0] m_axis_tdata,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  kdcl_cfg_t    cfg_q;
  kdcl_result_t next_res;
  kdcl_result_t out_q;
  logic         out_valid_q, out_valid_d;
  logic         in_beat;
  logic [NumKeys-1:0] sample;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DebounceReset;
      cfg_q.long_press_ticks <= LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgDebounce:  cfg_q.debounce_ticks   <= cfg_data_i[DebounceW-1:0];
        CfgLongPress: cfg_q.long_press_ticks <= cfg_data_i[HoldW-1:0];
        default:      ;
      endcase
    end
  end

  // output register can take a new beat when empty or draining this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // pins are active low
  assign sample = ~s_axis_tdata[NumKeys-1:0];

  kdcl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_beat),
    .sample_i (sample),
    .cfg_i    (cfg_q),
    .result_o (next_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_beat) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_q <= next_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'(out_q);

endmodule

`default_nettype wire

/* hw/rtl/kdcl_checker.sv */
`default_nettype none

module kdcl_checker
  import kdcl_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic [OutTdataW-1:0] m_axis_tdata,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready
);

  // a stalled output beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // an accepted input beat always shows up on the output next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted beat produced no result");

  // no click index without a click, and never a non-clickable key
  a_click_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[13] || m_axis_tdata[17:14] == 4'd0) &&
      m_axis_tdata[17:14] != 4'd9 && m_axis_tdata[17:14] != 4'd10 &&
      m_axis_tdata[17:14] <= 4'd12)
    else $error("bad click key");

  // a click beat never also carries a long-press pulse
  a_click_or_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[13] && m_axis_tdata[18]))
    else $error("click and long press in one beat");

  // long press only with the top key held
  a_long_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[8])
    else $error("long press without top key held");

endmodule

bind key_debounce_click_longpress kdcl_checker u_kdcl_checker (.*);

`default_nettype wire
